FILE: hdl/mme_pkg.sv
package mme_pkg;

    // defaults for the top level parameters
    localparam int MAX_DIM_DEF   = 16;
    localparam int ELEM_BITS_DEF = 16;

    // fixed field widths
    localparam int IDX_BITS     = 4;
    localparam int DIM_BITS     = 5;
    localparam int VAL_BITS     = 16;
    localparam int OUT_BITS     = 32;
    localparam int CFG_IDX_BITS = 2;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_A_ROWS    = 2'd0,
        CFG_INNER_DIM = 2'd1,
        CFG_B_COLS    = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg;

    // tag that travels with each multiply-accumulate term
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last_term;
        logic [IDX_BITS-1:0] col;
        logic                last_col;
    } t_tag;

    // one finished product element
    typedef struct packed {
        logic                       valid;
        logic [IDX_BITS-1:0]        col;
        logic                       last;
        logic signed [OUT_BITS-1:0] value;
    } t_res;

    // saturate a written dimension into 1..cap
    function automatic logic [DIM_BITS-1:0] f_clamp(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] cap);
        logic [DIM_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > cap) begin
            r = cap;
        end
        return r;
    endfunction

endpackage

FILE: hdl/matrix_multiply_engine.sv
// Dense matrix product engine over signed Q8.8 elements. Commands enter on
// start when busy is low. A load of an A or B element gives no result and
// leaves busy low; loads outside the configured size are dropped.
// A compute for an in-range row raises busy, then reads one A and one B element
// per cycle from the two element memories (one write and one read port each)
// and runs one multiply-accumulate per cycle; each product column takes one pass
// over the inner_dim terms. Results follow in ascending column order, and busy
// drops the cycle after the result marked last. A compute for a row at or
// beyond a_rows gives one error result on the next cycle. Results appear for
// one cycle under o_valid and cannot be held off.
// Element memories are not cleared; compute only over written entries.
// Configuration writes are accepted at any time but belong to idle periods.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic [IDX_BITS-1:0]        i_row_index,
    input  logic [IDX_BITS-1:0]        i_col_index,
    input  logic signed [VAL_BITS-1:0] i_elem_value,
    // configuration channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [DIM_BITS-1:0]        i_cfg_data,
    // result channel
    output logic                       o_valid,
    output logic [IDX_BITS-1:0]        o_out_row,
    output logic [IDX_BITS-1:0]        o_out_col,
    output logic signed [OUT_BITS-1:0] o_product_value,
    output logic                       o_last,
    output logic                       o_error
);

    localparam int DIM_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
    localparam int EW      = (ELEM_BITS < 16) ? ELEM_BITS : 16;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [DIM_BITS-1:0] CAP = DIM_BITS'(DIM_CAP);

    logic [DIM_BITS-1:0] r_a_rows;
    logic [DIM_BITS-1:0] r_inner;
    logic [DIM_BITS-1:0] r_b_cols;
    logic                r_busy;
    logic                r_issue;
    logic [IDX_BITS-1:0] r_row;
    logic [IDX_BITS-1:0] r_h;
    logic [IDX_BITS-1:0] r_j;
    logic                r_err_valid;
    t_tag                r_tag_rd;

    logic                accept;
    logic                we_a;
    logic                we_b;
    logic                cmp_go;
    logic                cmp_err;
    logic [ADDR_W-1:0]   waddr;
    logic [ADDR_W-1:0]   a_raddr;
    logic [ADDR_W-1:0]   b_raddr;
    logic [EW-1:0]       wdata;
    logic [EW-1:0]       a_rdata;
    logic [EW-1:0]       b_rdata;
    t_tag                issue_tag;
    t_res                mac_res;

    assign accept      = start & ~r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= CAP;
            r_inner  <= CAP;
            r_b_cols <= CAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_A_ROWS:    r_a_rows <= f_clamp(i_cfg_data, CAP);
                CFG_INNER_DIM: r_inner  <= f_clamp(i_cfg_data, CAP);
                CFG_B_COLS:    r_b_cols <= f_clamp(i_cfg_data, CAP);
                default: begin
                end
            endcase
        end
    end

    // command decode
    always_comb begin
        we_a    = 1'b0;
        we_b    = 1'b0;
        cmp_go  = 1'b0;
        cmp_err = 1'b0;
        unique case (t_cmd'(i_command))
            CMD_LOAD_A: begin
                we_a = accept && ({1'b0, i_row_index} < r_a_rows)
                              && ({1'b0, i_col_index} < r_inner);
            end
            CMD_LOAD_B: begin
                we_b = accept && ({1'b0, i_row_index} < r_inner)
                              && ({1'b0, i_col_index} < r_b_cols);
            end
            CMD_COMPUTE: begin
                cmp_go  = accept && ({1'b0, i_row_index} < r_a_rows);
                cmp_err = accept && ({1'b0, i_row_index} >= r_a_rows);
            end
            default: begin
            end
        endcase
    end

    assign waddr = ADDR_W'(i_row_index * MAX_DIM + i_col_index);
    assign wdata = i_elem_value[EW-1:0];

    // read address generation, one term per cycle
    assign a_raddr = ADDR_W'(r_row * MAX_DIM + r_h);
    assign b_raddr = ADDR_W'(r_h * MAX_DIM + r_j);

    always_comb begin
        issue_tag.valid     = r_issue;
        issue_tag.first     = (r_h == '0);
        issue_tag.last_term = ({1'b0, r_h} == r_inner - DIM_BITS'(1));
        issue_tag.col       = r_j;
        issue_tag.last_col  = ({1'b0, r_j} == r_b_cols - DIM_BITS'(1));
    end

    // sequencer over columns and inner terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_issue <= 1'b0;
            r_h     <= '0;
            r_j     <= '0;
        end else begin
            if (cmp_go) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_h     <= '0;
                r_j     <= '0;
            end else if (r_issue) begin
                if (issue_tag.last_term) begin
                    r_h <= '0;
                    if (issue_tag.last_col) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_j <= r_j + IDX_BITS'(1);
                    end
                end else begin
                    r_h <= r_h + IDX_BITS'(1);
                end
            end
            if (mac_res.valid && mac_res.last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_cmd'(i_command) == CMD_COMPUTE) begin
            r_row <= i_row_index;
        end
    end

    // error result for an out-of-range row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_valid <= 1'b0;
        end else begin
            r_err_valid <= cmp_err;
        end
    end

    // tag aligned with memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_rd <= '0;
        end else begin
            r_tag_rd <= issue_tag;
        end
    end

    mme_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (EW),
        .ADDR_W (ADDR_W)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mme_store #(
        .DEPTH  (DEPTH),
        .WIDTH  (EW),
        .ADDR_W (ADDR_W)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mme_mac #(
        .EW (EW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag_rd),
        .i_a     (signed'(a_rdata)),
        .i_b     (signed'(b_rdata)),
        .o_res   (mac_res)
    );

    // result ports
    assign o_valid         = r_err_valid | mac_res.valid;
    assign o_out_row       = r_row;
    assign o_out_col       = r_err_valid ? '0 : mac_res.col;
    assign o_product_value = r_err_valid ? '0 : mac_res.value;
    assign o_last          = r_err_valid | mac_res.last;
    assign o_error         = r_err_valid;

    // checks
    a_res_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_res.valid |-> r_busy)
        else $error("product result outside a busy period");

    a_issue_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issue |-> r_busy)
        else $error("term issued while not busy");

    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(mac_res.valid && mac_res.last))
        else $error("busy dropped without a last result");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_err_valid && mac_res.valid))
        else $error("error result collides with product result");

endmodule

FILE: hdl/mme_store.sv
module mme_store
    import mme_pkg::*;
#(
    parameter int DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int WIDTH  = ELEM_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mme_mac.sv
module mme_mac
    import mme_pkg::*;
#(
    parameter int EW = ELEM_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tag                 i_tag,
    input  logic signed [EW-1:0] i_a,
    input  logic signed [EW-1:0] i_b,
    output t_res                 o_res
);

    localparam int PROD_W = 2 * EW;
    localparam int ACC_W  = PROD_W + 5;

    t_tag                     r_t1;
    t_tag                     r_t2;
    t_res                     r_res;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [OUT_BITS-1:0] sat_value;

    // product stage
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
        end else begin
            r_t1 <= i_tag;
        end
    end

    // accumulate stage
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        if (r_t1.valid) begin
            n_acc = r_t1.first ? prod_ext : r_acc + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
        end else begin
            r_t2 <= '{valid: r_t1.valid & r_t1.last_term, first: r_t1.first,
                      last_term: r_t1.last_term, col: r_t1.col, last_col: r_t1.last_col};
        end
    end

    // saturate to the signed 32 bit range
    generate
        if (ACC_W <= OUT_BITS) begin : g_narrow
            assign sat_value = OUT_BITS'(r_acc);
        end else begin : g_wide
            always_comb begin
                if (r_acc[ACC_W-1:OUT_BITS-1] == '0 || r_acc[ACC_W-1:OUT_BITS-1] == '1) begin
                    sat_value = r_acc[OUT_BITS-1:0];
                end else if (r_acc[ACC_W-1]) begin
                    sat_value = {1'b1, {(OUT_BITS-1){1'b0}}};
                end else begin
                    sat_value = {1'b0, {(OUT_BITS-1){1'b1}}};
                end
            end
        end
    endgenerate

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= '{valid: r_t2.valid, col: r_t2.col, last: r_t2.last_col,
                       value: sat_value};
        end
    end

    assign o_res = r_res;

endmodule
